### sv/page_replacement_selector_macros.svh
`ifndef PAGE_REPLACEMENT_SELECTOR_MACROS_SVH
`define PAGE_REPLACEMENT_SELECTOR_MACROS_SVH

// same-cycle implication
`define PRS_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PRS_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

### sv/prs_pkg.sv
package prs_pkg;

    localparam int FRAME_W = 7;
    localparam int TIME_W  = 32;

    localparam logic [1:0] OP_REF    = 2'd0;
    localparam logic [1:0] OP_MAP    = 2'd1;
    localparam logic [1:0] OP_UNMAP  = 2'd2;
    localparam logic [1:0] OP_VICTIM = 2'd3;

    localparam logic [2:0] POL_FIFO   = 3'd0;
    localparam logic [2:0] POL_RANDOM = 3'd1;
    localparam logic [2:0] POL_CLOCK  = 3'd2;
    localparam logic [2:0] POL_ESC    = 3'd3;
    localparam logic [2:0] POL_AGING  = 3'd4;
    localparam logic [2:0] POL_WSET   = 3'd5;

    localparam logic [1:0] CFG_POLICY         = 2'd0;
    localparam logic [1:0] CFG_FRAME_COUNT    = 2'd1;
    localparam logic [1:0] CFG_CLEAR_INTERVAL = 2'd2;
    localparam logic [1:0] CFG_WINDOW_LENGTH  = 2'd3;

    localparam logic [7:0]        FRAME_COUNT_RST = 8'd128;
    localparam logic [15:0]       INTERVAL_RST    = 16'd50;
    localparam logic [TIME_W-1:0] TIME_MAX        = 32'hFFFF_FFFF;

    typedef struct packed {
        logic              referenced;
        logic              modified;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] last_use;
    } frame_entry_t;

    typedef struct packed {
        logic               re;
        logic [FRAME_W-1:0] raddr;
        logic               we;
        logic [FRAME_W-1:0] waddr;
        frame_entry_t       wdata;
    } mem_req_t;

endpackage

### sv/prs_frame_mem.sv
`include "page_replacement_selector_macros.svh"

module prs_frame_mem
    import prs_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  mem_req_t     req,
    output frame_entry_t rdata
);

    frame_entry_t     mem [DEPTH];
    frame_entry_t     data_reg;
    logic [DEPTH-1:0] valid_reg;
    logic             hit_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
        if (req.re)
        begin
            data_reg <= mem[req.raddr[AW-1:0]];
        end
    end

    // entries never written read as all zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                valid_reg[req.waddr[AW-1:0]] <= 1'b1;
            end
            if (req.re)
            begin
                hit_reg <= valid_reg[req.raddr[AW-1:0]];
            end
        end
    end

    assign rdata = hit_reg ? data_reg : '0;

    `PRS_ASSERT_NOW(a_no_rw_collision, req.re && req.we, req.raddr != req.waddr,
        "read and write hit the same frame")
    `PRS_ASSERT_NEXT(a_write_marks_valid, req.we, valid_reg[$past(req.waddr[AW-1:0])],
        "written frame not marked valid")
    `PRS_ASSERT_NEXT(a_read_hit_from_valid, req.re,
        hit_reg == $past(valid_reg[req.raddr[AW-1:0]]), "read hit flag mismatch")

endmodule

### sv/page_replacement_selector.sv
// Page replacement victim selector. Reference, map and unmap requests pass
// through idle, memory read and write back. A fifo victim request reads the
// frame at the hand; random first forms the 31-step remainder of random_value
// by the frame count; clock, enhanced second chance, aging and working set
// scan up to n frames, where n is frame_count held to the range 1..FRAMES:
// the frame table sits in one single-port-read RAM and the scan reads one
// frame per cycle while writing back the previous one.
// One request is in flight at a time; a finished victim waits in an output
// register, and a further victim holds until that register is taken.
`include "page_replacement_selector_macros.svh"

module page_replacement_selector
    import prs_pkg::*;
#(
    parameter int FRAMES = 128
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          op,
    input  logic [FRAME_W-1:0]  frame_id,
    input  logic                is_store,
    input  logic                wr_protect,
    input  logic [TIME_W-1:0]   current_time,
    input  logic [30:0]         random_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [FRAME_W-1:0]  victim_frame,
    output logic                victim_modified
);

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);

    typedef enum logic [2:0] {
        IDLE, RMW_RD, RMW_WR, DIV, ONE_RD, ONE_WAIT, SCAN, FIN
    } state_t;

    state_t              state_reg;
    logic [2:0]          policy_reg;
    logic [7:0]          frame_count_reg;
    logic [15:0]         clear_interval_reg;
    logic [15:0]         window_length_reg;

    logic [1:0]          op_reg;
    logic [IW-1:0]       fi_reg;
    logic                store_reg;
    logic                wprot_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [30:0]         rnd_reg;

    logic [2:0]          pol_reg;
    logic [CW-1:0]       n_reg;
    logic [IW-1:0]       hand_reg;
    logic [TIME_W-1:0]   last_clear_reg;
    logic                clear_reg;

    logic [IW-1:0]       rd_idx_reg;
    logic [CW-1:0]       issue_cnt_reg;
    logic [CW-1:0]       proc_cnt_reg;
    logic                pv_reg;
    logic [IW-1:0]       pidx_reg;

    logic [IW-1:0]       vic_reg;
    logic                vmod_reg;
    logic                found_reg;
    logic [TIME_W-1:0]   best_reg;
    logic [3:0]          first_v_reg;
    logic [IW-1:0]       first_idx_reg [4];
    logic [3:0]          first_mod_reg;

    logic [IW:0]         rem_reg;
    logic [4:0]          div_cnt_reg;

    logic                out_valid_reg;
    logic [FRAME_W-1:0]  out_frame_reg;
    logic                out_mod_reg;

    mem_req_t            req;
    frame_entry_t        rdata;
    logic [TIME_W-1:0]   new_age;
    logic [TIME_W-1:0]   elapsed;
    logic [1:0]          cls;
    logic                stop;
    logic                issue;
    logic [CW-1:0]       n_next;
    logic [IW-1:0]       hand_fix;
    logic [IW+1:0]       rem_shift;
    logic [IW-1:0]       fin_vic;
    logic                fin_mod;

    function automatic logic [IW-1:0] advance(input logic [IW-1:0] i, input logic [CW-1:0] n);
        logic [CW:0] s;
        s = (CW+1)'(i) + 1'b1;
        return (s >= (CW+1)'(n)) ? '0 : s[IW-1:0];
    endfunction

    prs_frame_mem #(
        .DEPTH (FRAMES),
        .AW    (IW)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg         <= POL_FIFO;
            frame_count_reg    <= FRAME_COUNT_RST;
            clear_interval_reg <= INTERVAL_RST;
            window_length_reg  <= INTERVAL_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_POLICY:         policy_reg         <= cfg_data[2:0];
                CFG_FRAME_COUNT:    frame_count_reg    <= cfg_data[7:0];
                CFG_CLEAR_INTERVAL: clear_interval_reg <= cfg_data;
                CFG_WINDOW_LENGTH:  window_length_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (frame_count_reg == 8'd0)
        begin
            n_next = CW'(1);
        end
        else if (frame_count_reg > 8'(FRAMES))
        begin
            n_next = CW'(FRAMES);
        end
        else
        begin
            n_next = CW'(frame_count_reg);
        end
        hand_fix  = ((CW+1)'(hand_reg) >= (CW+1)'(n_next)) ? '0 : hand_reg;
        rem_shift = {rem_reg, rnd_reg[30]};
    end

    always_comb
    begin
        req     = '0;
        new_age = {rdata.referenced, rdata.age[TIME_W-1:1]};
        elapsed = now_reg - rdata.last_use;
        cls     = {rdata.referenced, rdata.modified};
        stop    = 1'b0;
        issue   = (state_reg == SCAN) && (issue_cnt_reg < n_reg);
        unique case (state_reg)
            RMW_RD:
            begin
                req.re    = 1'b1;
                req.raddr = FRAME_W'(fi_reg);
            end
            RMW_WR:
            begin
                req.we    = 1'b1;
                req.waddr = FRAME_W'(fi_reg);
                req.wdata = rdata;
                case (op_reg)
                    OP_REF:
                    begin
                        req.wdata.referenced = 1'b1;
                        if (store_reg && !wprot_reg)
                        begin
                            req.wdata.modified = 1'b1;
                        end
                    end
                    OP_MAP:
                    begin
                        req.wdata.last_use = now_reg;
                        if (policy_reg == POL_AGING)
                        begin
                            req.wdata.age = '0;
                        end
                    end
                    default:
                    begin
                        req.wdata.referenced = 1'b0;
                        req.wdata.modified   = 1'b0;
                    end
                endcase
            end
            ONE_RD:
            begin
                req.re    = 1'b1;
                req.raddr = FRAME_W'(vic_reg);
            end
            SCAN:
            begin
                req.re    = issue;
                req.raddr = FRAME_W'(rd_idx_reg);
                req.waddr = FRAME_W'(pidx_reg);
                req.wdata = rdata;
                req.wdata.referenced = 1'b0;
                if (pv_reg)
                begin
                    case (pol_reg)
                        POL_CLOCK:
                        begin
                            req.we = rdata.referenced;
                            stop   = !rdata.referenced;
                        end
                        POL_ESC:
                        begin
                            stop   = !clear_reg && (cls == 2'd0);
                            req.we = clear_reg && rdata.referenced;
                        end
                        POL_AGING:
                        begin
                            req.we        = 1'b1;
                            req.wdata.age = new_age;
                        end
                        default:
                        begin
                            req.wdata.last_use = now_reg;
                            req.we = rdata.referenced;
                            stop   = !rdata.referenced && (elapsed >= TIME_W'(window_length_reg));
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    // lowest class wins when no early exit happened
    always_comb
    begin
        fin_vic = vic_reg;
        fin_mod = vmod_reg;
        if (pol_reg == POL_ESC && !found_reg)
        begin
            for (int c = 3; c >= 0; c--)
            begin
                if (first_v_reg[c])
                begin
                    fin_vic = first_idx_reg[c];
                    fin_mod = first_mod_reg[c];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            op_reg         <= OP_REF;
            fi_reg         <= '0;
            store_reg      <= 1'b0;
            wprot_reg      <= 1'b0;
            now_reg        <= '0;
            rnd_reg        <= '0;
            pol_reg        <= POL_FIFO;
            n_reg          <= CW'(1);
            hand_reg       <= '0;
            last_clear_reg <= '0;
            clear_reg      <= 1'b0;
            rd_idx_reg     <= '0;
            issue_cnt_reg  <= '0;
            proc_cnt_reg   <= '0;
            pv_reg         <= 1'b0;
            pidx_reg       <= '0;
            vic_reg        <= '0;
            vmod_reg       <= 1'b0;
            found_reg      <= 1'b0;
            best_reg       <= TIME_MAX;
            first_v_reg    <= '0;
            for (int c = 0; c < 4; c++)
            begin
                first_idx_reg[c] <= '0;
            end
            first_mod_reg  <= '0;
            rem_reg        <= '0;
            div_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_frame_reg  <= '0;
            out_mod_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= op;
                        fi_reg    <= frame_id[IW-1:0];
                        store_reg <= is_store;
                        wprot_reg <= wr_protect;
                        now_reg   <= current_time;
                        rnd_reg   <= random_value;
                        if (op != OP_VICTIM)
                        begin
                            state_reg <= (int'(frame_id) < FRAMES) ? RMW_RD : IDLE;
                        end
                        else
                        begin
                            n_reg         <= n_next;
                            hand_reg      <= hand_fix;
                            vic_reg       <= hand_fix;
                            rd_idx_reg    <= hand_fix;
                            found_reg     <= 1'b0;
                            best_reg      <= TIME_MAX;
                            first_v_reg   <= '0;
                            issue_cnt_reg <= '0;
                            proc_cnt_reg  <= '0;
                            pv_reg        <= 1'b0;
                            rem_reg       <= '0;
                            div_cnt_reg   <= '0;
                            clear_reg     <= (current_time - last_clear_reg)
                                             >= TIME_W'(clear_interval_reg);
                            if (policy_reg == POL_ESC
                                && (current_time - last_clear_reg)
                                   >= TIME_W'(clear_interval_reg))
                            begin
                                last_clear_reg <= current_time;
                            end
                            case (policy_reg)
                                POL_RANDOM:
                                begin
                                    pol_reg   <= POL_RANDOM;
                                    state_reg <= DIV;
                                end
                                POL_CLOCK, POL_ESC, POL_AGING, POL_WSET:
                                begin
                                    pol_reg   <= policy_reg;
                                    state_reg <= SCAN;
                                end
                                default:
                                begin
                                    pol_reg   <= POL_FIFO;
                                    state_reg <= ONE_RD;
                                end
                            endcase
                        end
                    end
                end
                RMW_RD:
                begin
                    state_reg <= RMW_WR;
                end
                RMW_WR:
                begin
                    state_reg <= IDLE;
                end
                DIV:
                begin
                    rnd_reg     <= {rnd_reg[29:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (rem_shift >= (IW+2)'(n_reg))
                    begin
                        rem_reg <= (IW+1)'(rem_shift - (IW+2)'(n_reg));
                    end
                    else
                    begin
                        rem_reg <= rem_shift[IW:0];
                    end
                    if (div_cnt_reg == 5'd30)
                    begin
                        if (rem_shift >= (IW+2)'(n_reg))
                        begin
                            vic_reg <= IW'(rem_shift - (IW+2)'(n_reg));
                        end
                        else
                        begin
                            vic_reg <= rem_shift[IW-1:0];
                        end
                        state_reg <= ONE_RD;
                    end
                end
                ONE_RD:
                begin
                    state_reg <= ONE_WAIT;
                end
                ONE_WAIT:
                begin
                    vmod_reg  <= rdata.modified;
                    state_reg <= FIN;
                end
                SCAN:
                begin
                    pv_reg   <= issue;
                    pidx_reg <= rd_idx_reg;
                    if (issue)
                    begin
                        rd_idx_reg    <= advance(rd_idx_reg, n_reg);
                        issue_cnt_reg <= issue_cnt_reg + 1'b1;
                    end
                    if (pv_reg)
                    begin
                        proc_cnt_reg <= proc_cnt_reg + 1'b1;
                        if (proc_cnt_reg == '0)
                        begin
                            vmod_reg <= rdata.modified;
                        end
                        if (pol_reg == POL_ESC && !stop && !first_v_reg[cls])
                        begin
                            first_v_reg[cls]   <= 1'b1;
                            first_idx_reg[cls] <= pidx_reg;
                            first_mod_reg[cls] <= rdata.modified;
                        end
                        if (pol_reg == POL_AGING && new_age < best_reg)
                        begin
                            best_reg <= new_age;
                            vic_reg  <= pidx_reg;
                            vmod_reg <= rdata.modified;
                        end
                        if (pol_reg == POL_WSET && !stop && !rdata.referenced
                            && rdata.last_use < best_reg)
                        begin
                            best_reg <= rdata.last_use;
                            vic_reg  <= pidx_reg;
                            vmod_reg <= rdata.modified;
                        end
                        if (stop)
                        begin
                            vic_reg   <= pidx_reg;
                            vmod_reg  <= rdata.modified;
                            found_reg <= 1'b1;
                            state_reg <= FIN;
                        end
                        else if (CW'(proc_cnt_reg + 1'b1) == n_reg)
                        begin
                            state_reg <= FIN;
                        end
                    end
                end
                FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_frame_reg <= FRAME_W'(fin_vic);
                        out_mod_reg   <= fin_mod;
                        if (pol_reg != POL_RANDOM)
                        begin
                            hand_reg <= advance(fin_vic, n_reg);
                        end
                        state_reg <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign in_ready        = (state_reg == IDLE);
    assign out_valid       = out_valid_reg;
    assign victim_frame    = out_frame_reg;
    assign victim_modified = out_mod_reg;

    `PRS_ASSERT_NEXT(a_victim_blocks_input, in_valid && in_ready && op == OP_VICTIM,
        !in_ready, "victim request did not block input")
    `PRS_ASSERT_NOW(a_scan_bounded, state_reg == SCAN,
        proc_cnt_reg < n_reg && issue_cnt_reg <= n_reg, "scan ran past frame count")
    `PRS_ASSERT_NEXT(a_hand_in_range, state_reg == FIN && (!out_valid_reg || out_ready),
        (CW+1)'(hand_reg) < (CW+1)'(n_reg), "hand outside frame count")

endmodule
